// ----- hdl/rrl_pkg.sv -----
package rrl_pkg;

   // item kinds
   typedef enum logic [1:0] {
      ACT_START  = 2'd0,
      ACT_UPDATE = 2'd1,
      ACT_TICK   = 2'd2,
      ACT_STOP   = 2'd3
   } action_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BUSY       = 2'd1,
      ST_NOT_ACTIVE = 2'd2
   } status_type;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_STEP     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STABLE_LIMIT = 2'd2;

   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned FREQ_W     = 32;
   localparam int unsigned TICK_W     = 16;
   localparam int unsigned COUNT_W    = 4;

   localparam logic [TICK_W-1:0]  MIN_STEP_RESET     = 16'd10;
   localparam logic [TICK_W-1:0]  WINDOW_RESET       = 16'd20;
   localparam logic [COUNT_W-1:0] STABLE_LIMIT_RESET = 4'd3;

   typedef struct packed {
      logic [TICK_W-1:0]  min_step_hz;
      logic [TICK_W-1:0]  window_ticks;
      logic [COUNT_W-1:0] stable_apply_limit;
   } cfg_type;

   typedef struct packed {
      action_type        action;
      logic [FREQ_W-1:0] frequency_hz;
      logic              transmitting;
   } item_type;

   typedef struct packed {
      status_type        status;
      logic              apply_strobe;
      logic [FREQ_W-1:0] apply_frequency_hz;
      logic              session_active;
      logic              rate_limited;
      logic [FREQ_W-1:0] requested_hz;
      logic [FREQ_W-1:0] pending_hz;
      logic [FREQ_W-1:0] applied_hz;
   } rsp_word_type;

endpackage

// ----- hdl/rrl_req_if.sv -----
interface rrl_req_if import rrl_pkg::*; ();
   logic              valid;
   logic              ready;
   action_type        action;
   logic [FREQ_W-1:0] frequency_hz;
   logic              transmitting;

   modport source (output valid, output action, output frequency_hz, output transmitting,
                   input ready);
   modport sink   (input valid, input action, input frequency_hz, input transmitting,
                   output ready);
endinterface

// ----- hdl/rrl_rsp_if.sv -----
interface rrl_rsp_if import rrl_pkg::*; ();
   logic              valid;
   logic              ready;
   status_type        status;
   logic              apply_strobe;
   logic [FREQ_W-1:0] apply_frequency_hz;
   logic              session_active;
   logic              rate_limited;
   logic [FREQ_W-1:0] requested_hz;
   logic [FREQ_W-1:0] pending_hz;
   logic [FREQ_W-1:0] applied_hz;

   modport source (output valid, output status, output apply_strobe,
                   output apply_frequency_hz, output session_active, output rate_limited,
                   output requested_hz, output pending_hz, output applied_hz,
                   input ready);
   modport sink   (input valid, input status, input apply_strobe,
                   input apply_frequency_hz, input session_active, input rate_limited,
                   input requested_hz, input pending_hz, input applied_hz,
                   output ready);
endinterface

// ----- hdl/rrl_csr_if.sv -----
interface rrl_csr_if import rrl_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/retune_rate_limiter_unit.sv -----
// retune rate limiter: an accepted req word enters the input register
// throughput one word per cycle while rsp is not stalled; the session state
// updates as the word moves from the input register to the result register
// a stalled rsp backs up into the input register, then req ready drops
// reset (synchronous, active high) empties both registers, clears the session
// and loads min_step_hz 10, window_ticks 20, stable_apply_limit 3
module retune_rate_limiter_unit import rrl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rrl_req_if.sink    req_chan,
   rrl_rsp_if.source  rsp_chan,
   rrl_csr_if.sink    csr_chan
);

   cfg_type      cfg;
   item_type     item_ff,    item_in;
   logic         in_vld_ff,  in_vld_in;
   rsp_word_type word;
   rsp_word_type out_ff,     out_in;
   logic         out_vld_ff, out_vld_in;
   logic         advance;
   logic         req_take;

   // configuration registers
   rrl_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // a word moves on when the result register is empty or being drained
   assign advance  = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   // input register
   always_comb begin
      item_in.action       = req_chan.action;
      item_in.frequency_hz = req_chan.frequency_hz;
      item_in.transmitting = req_chan.transmitting;
      if (!req_take) begin
         item_in = item_ff;
      end
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
   end

   // session state and next-state logic, one word per cycle while words advance
   rrl_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .word    (word)
   );

   // result register
   always_comb begin
      out_in = advance ? word : out_ff;
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      out_ff  <= out_in;
   end

   assign rsp_chan.valid              = out_vld_ff;
   assign rsp_chan.status             = out_ff.status;
   assign rsp_chan.apply_strobe       = out_ff.apply_strobe;
   assign rsp_chan.apply_frequency_hz = out_ff.apply_frequency_hz;
   assign rsp_chan.session_active     = out_ff.session_active;
   assign rsp_chan.rate_limited       = out_ff.rate_limited;
   assign rsp_chan.requested_hz       = out_ff.requested_hz;
   assign rsp_chan.pending_hz         = out_ff.pending_hz;
   assign rsp_chan.applied_hz         = out_ff.applied_hz;

endmodule

// ----- hdl/rrl_csr.sv -----
module rrl_csr import rrl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rrl_csr_if.sink   csr_chan,
   output cfg_type   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_chan.ready = 1'b1;
   assign wr_en          = csr_chan.valid;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_chan.index)
            CSR_MIN_STEP:     cfg_in.min_step_hz        = csr_chan.data;
            CSR_WINDOW:       cfg_in.window_ticks       = csr_chan.data;
            CSR_STABLE_LIMIT: cfg_in.stable_apply_limit = csr_chan.data[COUNT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_step_hz        <= MIN_STEP_RESET;
         cfg_ff.window_ticks       <= WINDOW_RESET;
         cfg_ff.stable_apply_limit <= STABLE_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hdl/rrl_core.sv -----
module rrl_core import rrl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  item_type     item,
   input  cfg_type      cfg,
   output rsp_word_type word
);

   logic              active_ff,    active_in;
   logic              mode_ff,      mode_in;
   logic [FREQ_W-1:0] requested_ff, requested_in;
   logic [FREQ_W-1:0] pending_ff,   pending_in;
   logic [FREQ_W-1:0] applied_ff,   applied_in;
   logic [TICK_W-1:0] elapsed_ff,   elapsed_in;
   logic [COUNT_W-1:0] count_ff,    count_in;

   logic [FREQ_W-1:0]  min_step_wide;
   logic [FREQ_W-1:0]  upd_ref;
   logic               upd_big;
   logic               pend_close;
   logic [TICK_W-1:0]  elapsed_inc;
   logic [COUNT_W-1:0] count_inc;
   status_type         status;
   logic               strobe;
   logic [FREQ_W-1:0]  strobe_freq;

   function automatic logic [FREQ_W-1:0] abs_diff(input logic [FREQ_W-1:0] a,
                                                  input logic [FREQ_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   assign min_step_wide = {{(FREQ_W-TICK_W){1'b0}}, cfg.min_step_hz};
   assign upd_ref       = (pending_ff != '0) ? pending_ff : applied_ff;
   assign upd_big       = abs_diff(item.frequency_hz, upd_ref) >= min_step_wide;
   assign pend_close    = abs_diff(pending_ff, applied_ff) < min_step_wide;
   assign elapsed_inc   = (elapsed_ff != '1) ? elapsed_ff + 1'b1 : elapsed_ff;
   assign count_inc     = count_ff + 1'b1;

   always_comb begin
      active_in    = active_ff;
      mode_in      = mode_ff;
      requested_in = requested_ff;
      pending_in   = pending_ff;
      applied_in   = applied_ff;
      elapsed_in   = elapsed_ff;
      count_in     = count_ff;
      status       = ST_OK;
      strobe       = 1'b0;
      strobe_freq  = '0;
      case (item.action)
         ACT_START: begin
            if (active_ff) begin
               status = ST_BUSY;
            end else begin
               active_in    = 1'b1;
               mode_in      = 1'b0;
               requested_in = item.frequency_hz;
               pending_in   = '0;
               applied_in   = item.frequency_hz;
               elapsed_in   = '0;
               count_in     = '0;
               strobe       = 1'b1;
               strobe_freq  = item.frequency_hz;
            end
         end
         ACT_UPDATE: begin
            if (!active_ff) begin
               status = ST_NOT_ACTIVE;
            end else begin
               requested_in = item.frequency_hz;
               if (upd_big) begin
                  // retarget before the old target was applied
                  if (pending_ff != '0 && pending_ff != item.frequency_hz) begin
                     mode_in = 1'b1;
                  end
                  pending_in = item.frequency_hz;
               end
            end
         end
         ACT_TICK: begin
            if (active_ff) begin
               if (!item.transmitting) begin
                  active_in    = 1'b0;
                  mode_in      = 1'b0;
                  requested_in = '0;
                  pending_in   = '0;
                  applied_in   = '0;
                  elapsed_in   = '0;
                  count_in     = '0;
               end else begin
                  elapsed_in = elapsed_inc;
                  if (pending_ff != '0) begin
                     if (pend_close) begin
                        pending_in = '0;
                     end else if (!mode_ff || elapsed_inc >= cfg.window_ticks) begin
                        applied_in  = pending_ff;
                        strobe      = 1'b1;
                        strobe_freq = pending_ff;
                        pending_in  = '0;
                        elapsed_in  = '0;
                        if (mode_ff) begin
                           if (count_inc >= cfg.stable_apply_limit) begin
                              mode_in  = 1'b0;
                              count_in = '0;
                           end else begin
                              count_in = count_inc;
                           end
                        end
                     end
                  end
               end
            end
         end
         default: begin
            active_in    = 1'b0;
            mode_in      = 1'b0;
            requested_in = '0;
            pending_in   = '0;
            applied_in   = '0;
            elapsed_in   = '0;
            count_in     = '0;
         end
      endcase
   end

   always_comb begin
      word.status             = status;
      word.apply_strobe       = strobe;
      word.apply_frequency_hz = strobe_freq;
      word.session_active     = active_in;
      word.rate_limited       = mode_in;
      word.requested_hz       = requested_in;
      word.pending_hz         = pending_in;
      word.applied_hz         = applied_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         mode_ff      <= 1'b0;
         requested_ff <= '0;
         pending_ff   <= '0;
         applied_ff   <= '0;
         elapsed_ff   <= '0;
         count_ff     <= '0;
      end else if (step_en) begin
         active_ff    <= active_in;
         mode_ff      <= mode_in;
         requested_ff <= requested_in;
         pending_ff   <= pending_in;
         applied_ff   <= applied_in;
         elapsed_ff   <= elapsed_in;
         count_ff     <= count_in;
      end
   end

endmodule

// ----- hdl/rrl_checker.sv -----
module rrl_checker import rrl_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input status_type        rsp_status,
   input logic              rsp_apply_strobe,
   input logic [FREQ_W-1:0] rsp_apply_frequency_hz,
   input logic              rsp_session_active,
   input logic              rsp_rate_limited,
   input logic [FREQ_W-1:0] rsp_requested_hz,
   input logic [FREQ_W-1:0] rsp_pending_hz,
   input logic [FREQ_W-1:0] rsp_applied_hz
);

   // a retune only happens inside a session
   a_strobe_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_apply_strobe |-> rsp_session_active && rsp_status == ST_OK)
      else $error("retune reported outside an ok active session");

   // no retune frequency shown without a strobe
   a_freq_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_apply_strobe |-> rsp_apply_frequency_hz == '0)
      else $error("apply frequency nonzero without strobe");

   // an idle session holds reset state
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_session_active |->
         !rsp_rate_limited && rsp_requested_hz == '0 && rsp_pending_hz == '0 &&
         rsp_applied_hz == '0)
      else $error("idle session carries stale state");

   // a strobe always leaves nothing pending and the applied value updated
   a_strobe_applied: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_apply_strobe |->
         rsp_pending_hz == '0 && rsp_applied_hz == rsp_apply_frequency_hz)
      else $error("strobe does not match applied frequency");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

endmodule

bind retune_rate_limiter_unit rrl_checker u_rrl_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_chan.valid),
   .rsp_ready              (rsp_chan.ready),
   .rsp_status             (rsp_chan.status),
   .rsp_apply_strobe       (rsp_chan.apply_strobe),
   .rsp_apply_frequency_hz (rsp_chan.apply_frequency_hz),
   .rsp_session_active     (rsp_chan.session_active),
   .rsp_rate_limited       (rsp_chan.rate_limited),
   .rsp_requested_hz       (rsp_chan.requested_hz),
   .rsp_pending_hz         (rsp_chan.pending_hz),
   .rsp_applied_hz         (rsp_chan.applied_hz)
);
